[sv/c8x_pkg.sv]
package c8x_pkg;

    // input item modes (tuser of the input stream)
    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;
    localparam logic [1:0] MODE_COLL = 2'd3;

    // result kinds (tuser of the output stream)
    localparam logic [2:0] KIND_DONE  = 3'd0;
    localparam logic [2:0] KIND_STORE = 3'd1;
    localparam logic [2:0] KIND_LOAD  = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_DRAW  = 3'd4;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEI  = 4'h3;
    localparam logic [3:0] GRP_SNEI = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_LDIX = 4'hA;
    localparam logic [3:0] GRP_JPV0 = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;
    localparam logic [3:0] GRP_MISC = 4'hF;

    // whole opcodes of the system group
    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    // alu sub-ops (low nibble of group 8)
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // key group sub-ops
    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    // misc group sub-ops
    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    localparam logic [3:0] FLAG_REG = 4'hF;

endpackage

[sv/c8x_ram.sv]
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/chip8_instruction_executor.sv]
// channel  | dir | handshake              | payload
// s_axis   | in  | tvalid/tready          | tuser mode, tdata opcode..collision
// m_axis   | out | tvalid/tready, tlast   | tuser kind, tdata address..sound_active
// cfg      | in  | cfg_wr_en (no wait)    | cfg_wr_data start address of the program
//
// an opcode without memory beats steps through accept, read vx, read vy/v0,
// execute, vx writeback, done beat; v0-vf sit in a one-read-port ram, which sets this.
// block stores do a ram read and then a beat per byte; other beats need no ram read.
// timer ticks and load/collision returns skip the vx writeback step.
// reset sets pc to 512 and zeroes i, sp, timers and v0-vf; no clearing pass is needed.
// a stalled output holds the sequencer; input is taken only between items.
module chip8_instruction_executor
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[15:0], key_mask[31:16], random_byte[39:32], return_index[43:40],
    // return_data[51:44], collision[52], zero pad
    input  logic [55:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // address[11:0], data[19:12], target_register[23:20], draw_x[31:24],
    // draw_y[39:32], sprite_rows[43:40], next_pc[55:44], sound_active[56], zero pad
    output logic [63:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDX  = 4'd1;
    localparam logic [3:0] S_RDY  = 4'd2;
    localparam logic [3:0] S_EXEC = 4'd3;
    localparam logic [3:0] S_WX   = 4'd4;
    localparam logic [3:0] S_CLR  = 4'd5;
    localparam logic [3:0] S_DRAW = 4'd6;
    localparam logic [3:0] S_BCD  = 4'd7;
    localparam logic [3:0] S_BRD  = 4'd8;
    localparam logic [3:0] S_BWR  = 4'd9;
    localparam logic [3:0] S_LD   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [11:0]     pc_reg, pc_next;
    logic [11:0]     i_reg, i_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [7:0]      dt_reg, dt_next;
    logic [7:0]      st_reg, st_next;
    logic [15:0]     vvalid_reg, vvalid_next;
    logic [3:0]      vrd_addr_reg, vrd_addr_next;

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] op_reg, op_next;
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [3:0]  ridx_reg, ridx_next;
    logic [7:0]  rdat_reg, rdat_next;
    logic        coll_reg, coll_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic        vxw_reg, vxw_next;
    logic [7:0]  vxv_reg, vxv_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  ones_reg, ones_next;
    logic [3:0]  tens_reg, tens_next;
    logic [1:0]  hun_reg, hun_next;

    // output register
    logic        ov_reg;
    logic [2:0]  o_kind_reg;
    logic [11:0] o_addr_reg;
    logic [7:0]  o_data_reg;
    logic [3:0]  o_tgt_reg;
    logic [7:0]  o_dx_reg;
    logic [7:0]  o_dy_reg;
    logic [3:0]  o_rows_reg;
    logic [11:0] o_npc_reg;
    logic        o_snd_reg;
    logic        o_last_reg;

    logic        emit;
    logic [2:0]  e_kind;
    logic [11:0] e_addr;
    logic [7:0]  e_data;
    logic [3:0]  e_tgt;
    logic [7:0]  e_dx;
    logic [7:0]  e_dy;
    logic [3:0]  e_rows;
    logic        e_last;

    logic            v_we, v_re;
    logic [3:0]      v_waddr, v_raddr;
    logic [7:0]      v_wdata, v_rdata, vq;
    logic            st_we, st_re;
    logic [SA_W-1:0] st_waddr, st_raddr;
    logic [11:0]     st_wdata, st_rdata;

    logic            in_acc, can_emit;
    logic [SP_W-1:0] sp_dec;
    logic [3:0]      x, n;
    logic [7:0]      kk;
    logic [11:0]     nnn, pc2, pc4;
    logic [8:0]      sum9;
    logic [15:0]     mul_t, mul_h;
    logic [7:0]      ones8;
    logic [4:0]      tens_all;
    logic            key_hit;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign can_emit      = !ov_reg || m_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {7'd0, o_snd_reg, o_npc_reg, o_rows_reg, o_dy_reg, o_dx_reg,
                            o_tgt_reg, o_data_reg, o_addr_reg};

    // register file and return stack
    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // never-written registers read as zero
    assign vq = vvalid_reg[vrd_addr_reg] ? v_rdata : 8'h00;

    // opcode fields and shared arithmetic
    assign x      = op_reg[11:8];
    assign n      = op_reg[3:0];
    assign kk     = op_reg[7:0];
    assign nnn    = op_reg[11:0];
    assign pc2    = pc_reg + 12'd2;
    assign pc4    = pc_reg + 12'd4;
    assign sum9   = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign sp_dec = (sp_reg != '0) ? sp_reg - SP_W'(1) : '0;
    assign key_hit = (vx_reg[7:4] == 4'd0) ? keys_reg[vx_reg[3:0]] : 1'b0;

    // decimal digits by reciprocal multiply
    assign mul_t    = 16'(vx_reg) * 16'd205;
    assign mul_h    = 16'(vx_reg) * 16'd41;
    assign tens_all = mul_t[15:11];
    assign ones8    = vx_reg - 8'(tens_all) * 8'd10;

    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        i_next        = i_reg;
        sp_next       = sp_reg;
        dt_next       = dt_reg;
        st_next       = st_reg;
        vvalid_next   = vvalid_reg;
        vrd_addr_next = vrd_addr_reg;
        mode_next     = mode_reg;
        op_next       = op_reg;
        keys_next     = keys_reg;
        rnd_next      = rnd_reg;
        ridx_next     = ridx_reg;
        rdat_next     = rdat_reg;
        coll_next     = coll_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        vxw_next      = vxw_reg;
        vxv_next      = vxv_reg;
        cnt_next      = cnt_reg;
        ones_next     = ones_reg;
        tens_next     = tens_reg;
        hun_next      = hun_reg;

        v_we     = 1'b0;
        v_waddr  = 4'd0;
        v_wdata  = 8'd0;
        v_re     = 1'b0;
        v_raddr  = 4'd0;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = pc2;
        st_re    = 1'b0;
        st_raddr = sp_dec[SA_W-1:0];

        emit   = 1'b0;
        e_kind = KIND_DONE;
        e_addr = 12'd0;
        e_data = 8'd0;
        e_tgt  = 4'd0;
        e_dx   = 8'd0;
        e_dy   = 8'd0;
        e_rows = 4'd0;
        e_last = 1'b0;

        case (state_reg)
            // take a beat, start the vx and stack reads
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next = s_axis_tuser;
                    op_next   = s_axis_tdata[15:0];
                    keys_next = s_axis_tdata[31:16];
                    rnd_next  = s_axis_tdata[39:32];
                    ridx_next = s_axis_tdata[43:40];
                    rdat_next = s_axis_tdata[51:44];
                    coll_next = s_axis_tdata[52];
                    v_re      = 1'b1;
                    v_raddr   = s_axis_tdata[11:8];
                    st_re     = 1'b1;
                    state_next = S_RDX;
                end
            end

            // vx arrives, read vy (v0 for the offset jump)
            S_RDX:
            begin
                vx_next = vq;
                v_re    = 1'b1;
                v_raddr = (op_reg[15:12] == GRP_JPV0) ? 4'd0 : op_reg[7:4];
                state_next = S_RDY;
            end

            S_RDY:
            begin
                vy_next    = vq;
                state_next = S_EXEC;
            end

            // execute: pc, index, stack, timers, flag and register-load writes
            S_EXEC:
            begin
                vxw_next  = 1'b0;
                vxv_next  = 8'd0;
                cnt_next  = 4'd0;
                ones_next = ones8[3:0];
                tens_next = 4'(tens_all - 5'(mul_h[13:12]) * 5'd10);
                hun_next  = mul_h[13:12];
                state_next = S_WX;
                case (mode_reg)
                    MODE_TICK:
                    begin
                        if (dt_reg != 8'd0) dt_next = dt_reg - 8'd1;
                        if (st_reg != 8'd0) st_next = st_reg - 8'd1;
                        state_next = S_DONE;
                    end
                    MODE_LOAD:
                    begin
                        v_we    = 1'b1;
                        v_waddr = ridx_reg;
                        v_wdata = rdat_reg;
                        state_next = S_DONE;
                    end
                    MODE_COLL:
                    begin
                        v_we    = 1'b1;
                        v_waddr = FLAG_REG;
                        v_wdata = {7'd0, coll_reg};
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        pc_next = pc2;
                        case (op_reg[15:12])
                            GRP_SYS:
                            begin
                                if (op_reg == OPC_RET)
                                begin
                                    sp_next = sp_dec;
                                    pc_next = st_rdata;
                                end
                            end
                            GRP_JP:   pc_next = nnn;
                            GRP_CALL:
                            begin
                                st_we = 1'b1;
                                if (sp_reg < SP_W'(STACK_DEPTH))
                                begin
                                    st_waddr = sp_reg[SA_W-1:0];
                                    sp_next  = sp_reg + SP_W'(1);
                                end
                                else
                                begin
                                    st_waddr = SA_W'(STACK_DEPTH - 1);
                                end
                                pc_next = nnn;
                            end
                            GRP_SEI:  if (vx_reg == kk) pc_next = pc4;
                            GRP_SNEI: if (vx_reg != kk) pc_next = pc4;
                            GRP_SER:  if (n == 4'd0 && vx_reg == vy_reg) pc_next = pc4;
                            GRP_SNER: if (n == 4'd0 && vx_reg != vy_reg) pc_next = pc4;
                            GRP_LDI:
                            begin
                                vxw_next = 1'b1;
                                vxv_next = kk;
                            end
                            GRP_ADDI:
                            begin
                                vxw_next = 1'b1;
                                vxv_next = vx_reg + kk;
                            end
                            GRP_ALU:
                            begin
                                v_waddr = FLAG_REG;
                                case (n)
                                    ALU_MOV:
                                    begin
                                        vxw_next = 1'b1;
                                        vxv_next = vy_reg;
                                    end
                                    ALU_OR:
                                    begin
                                        vxw_next = 1'b1;
                                        vxv_next = vx_reg | vy_reg;
                                    end
                                    ALU_AND:
                                    begin
                                        vxw_next = 1'b1;
                                        vxv_next = vx_reg & vy_reg;
                                    end
                                    ALU_XOR:
                                    begin
                                        vxw_next = 1'b1;
                                        vxv_next = vx_reg ^ vy_reg;
                                    end
                                    ALU_ADD:
                                    begin
                                        v_we     = 1'b1;
                                        v_wdata  = {7'd0, sum9[8]};
                                        vxw_next = 1'b1;
                                        vxv_next = sum9[7:0];
                                    end
                                    ALU_SUB:
                                    begin
                                        v_we     = 1'b1;
                                        v_wdata  = {7'd0, vx_reg > vy_reg};
                                        vxw_next = 1'b1;
                                        vxv_next = vx_reg - vy_reg;
                                    end
                                    ALU_SHR:
                                    begin
                                        v_we     = 1'b1;
                                        v_wdata  = {7'd0, vy_reg[0]};
                                        vxw_next = 1'b1;
                                        vxv_next = {1'b0, vy_reg[7:1]};
                                    end
                                    ALU_SBN:
                                    begin
                                        v_we     = 1'b1;
                                        v_wdata  = {7'd0, vy_reg > vx_reg};
                                        vxw_next = 1'b1;
                                        vxv_next = vy_reg - vx_reg;
                                    end
                                    ALU_SHL:
                                    begin
                                        v_we     = 1'b1;
                                        v_wdata  = {7'd0, vy_reg[7]};
                                        vxw_next = 1'b1;
                                        vxv_next = {vy_reg[6:0], 1'b0};
                                    end
                                    default: ;
                                endcase
                            end
                            GRP_LDIX: i_next  = nnn;
                            GRP_JPV0: pc_next = nnn + {4'd0, vy_reg};
                            GRP_RND:
                            begin
                                vxw_next = 1'b1;
                                vxv_next = rnd_reg & kk;
                            end
                            GRP_DRW:
                            begin
                                v_we    = 1'b1;
                                v_waddr = FLAG_REG;
                                v_wdata = 8'd0;
                            end
                            GRP_KEY:
                            begin
                                if ((kk == KEY_DOWN && key_hit) || (kk == KEY_UP && !key_hit))
                                    pc_next = pc4;
                            end
                            default:
                            begin
                                case (kk)
                                    FX_GET_DT:
                                    begin
                                        vxw_next = 1'b1;
                                        vxv_next = dt_reg;
                                    end
                                    FX_SET_DT: dt_next = vx_reg;
                                    FX_SET_ST: st_next = vx_reg;
                                    FX_ADD_I:  i_next  = i_reg + {4'd0, vx_reg};
                                    FX_FONT:   i_next  = {2'd0, vx_reg, 2'd0} + {4'd0, vx_reg};
                                    default: ;
                                endcase
                            end
                        endcase
                    end
                endcase
            end

            // vx writeback, then pick the beat sequence
            S_WX:
            begin
                if (vxw_reg)
                begin
                    v_we    = 1'b1;
                    v_waddr = x;
                    v_wdata = vxv_reg;
                end
                if (op_reg == OPC_CLS)
                    state_next = S_CLR;
                else if (op_reg[15:12] == GRP_DRW)
                    state_next = S_DRAW;
                else if (op_reg[15:12] == GRP_MISC && kk == FX_BCD)
                    state_next = S_BCD;
                else if (op_reg[15:12] == GRP_MISC && kk == FX_STORE)
                    state_next = S_BRD;
                else if (op_reg[15:12] == GRP_MISC && kk == FX_LOAD)
                    state_next = S_LD;
                else
                    state_next = S_DONE;
            end

            S_CLR:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_CLEAR;
                    state_next = S_DONE;
                end
            end

            S_DRAW:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_DRAW;
                    e_addr = i_reg;
                    e_dx   = vx_reg;
                    e_dy   = vy_reg;
                    e_rows = n;
                    state_next = S_DONE;
                end
            end

            // ones at i+2, tens at i+1, hundreds at i
            S_BCD:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_STORE;
                    case (cnt_reg[1:0])
                        2'd0:
                        begin
                            e_addr = i_reg + 12'd2;
                            e_data = {4'd0, ones_reg};
                        end
                        2'd1:
                        begin
                            e_addr = i_reg + 12'd1;
                            e_data = {4'd0, tens_reg};
                        end
                        default:
                        begin
                            e_addr = i_reg;
                            e_data = {6'd0, hun_reg};
                        end
                    endcase
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd2) state_next = S_DONE;
                end
            end

            // block store: read vk, then send it
            S_BRD:
            begin
                v_re    = 1'b1;
                v_raddr = cnt_reg;
                state_next = S_BWR;
            end

            S_BWR:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_STORE;
                    e_addr = i_reg;
                    e_data = vq;
                    i_next = i_reg + 12'd1;
                    cnt_next = cnt_reg + 4'd1;
                    state_next = (cnt_reg == x) ? S_DONE : S_BRD;
                end
            end

            // block load requests
            S_LD:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_LOAD;
                    e_addr = i_reg;
                    e_tgt  = cnt_reg;
                    i_next = i_reg + 12'd1;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == x) state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_DONE;
                    e_last = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (v_we) vvalid_next[v_waddr] = 1'b1;
        if (v_re) vrd_addr_next = v_raddr;

        // start address write loads the pc
        if (cfg_wr_en)
        begin
            pc_next = cfg_wr_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= 12'd512;
            i_reg        <= 12'd0;
            sp_reg       <= '0;
            dt_reg       <= 8'd0;
            st_reg       <= 8'd0;
            vvalid_reg   <= 16'd0;
            vrd_addr_reg <= 4'd0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pc_reg       <= pc_next;
            i_reg        <= i_next;
            sp_reg       <= sp_next;
            dt_reg       <= dt_next;
            st_reg       <= st_next;
            vvalid_reg   <= vvalid_next;
            vrd_addr_reg <= vrd_addr_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    // item payload and output beat
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        op_reg   <= op_next;
        keys_reg <= keys_next;
        rnd_reg  <= rnd_next;
        ridx_reg <= ridx_next;
        rdat_reg <= rdat_next;
        coll_reg <= coll_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        vxw_reg  <= vxw_next;
        vxv_reg  <= vxv_next;
        cnt_reg  <= cnt_next;
        ones_reg <= ones_next;
        tens_reg <= tens_next;
        hun_reg  <= hun_next;
        if (emit)
        begin
            o_kind_reg <= e_kind;
            o_addr_reg <= e_addr;
            o_data_reg <= e_data;
            o_tgt_reg  <= e_tgt;
            o_dx_reg   <= e_dx;
            o_dy_reg   <= e_dy;
            o_rows_reg <= e_rows;
            o_npc_reg  <= pc_reg;
            o_snd_reg  <= (st_reg != 8'd0);
            o_last_reg <= e_last;
        end
    end

    // stack pointer stays within the stack
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // no register write lands on an entry being read
    assert property (@(posedge clk) disable iff (!rst_n)
        !(v_we && v_re && v_waddr == v_raddr))
        else $error("register file read and write collide");

    // the done beat and only it closes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (o_last_reg == (o_kind_reg == KIND_DONE)))
        else $error("tlast does not match done beat");

    // an accepted beat starts the operand reads
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_RDX)
        else $error("accepted beat did not start execution");

    // a new beat is never loaded over one that is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!ov_reg || m_axis_tready))
        else $error("output beat overwritten");

endmodule
